/* src/tlv_record_deframer_core_defines.svh */
// Assertion macros used by the deframer checker
`ifndef TLV_RECORD_DEFRAMER_CORE_DEFINES_SVH
`define TLV_RECORD_DEFRAMER_CORE_DEFINES_SVH

// Next-cycle implication, masked while reset is high
`define TLV_RDF_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// Next-cycle implication that also holds across reset
`define TLV_RDF_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

/* src/tlv_rdf_pkg.sv */
package tlv_rdf_pkg;

  // Parser phases
  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_VAL  = 2'd2;
  localparam logic [1:0] PH_DROP = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_VALUE    = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_REC_LONG = 3'd2;
  localparam logic [2:0] ST_MSG_LONG = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE = 1'd1;

  localparam logic [15:0] MAX_RECORD_RST  = 16'd4096;
  localparam logic [15:0] MAX_MESSAGE_RST = 16'd8192;

  // Header layout and the byte sent for an empty record
  localparam logic [2:0] TAG_BYTES    = 3'd2;
  localparam logic [2:0] HEADER_BYTES = 3'd6;
  localparam logic [7:0] EMPTY_BYTE   = 8'h30;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] tag;
    logic [15:0] item_length;
    logic [15:0] value_index;
    logic [7:0]  value_byte;
    logic        item_end;
  } res_word_t;

  // Up to two results produced by one input word
  typedef struct packed {
    logic [1:0] count;
    res_word_t  r0;
    res_word_t  r1;
  } push_t;

endpackage

/* src/tlv_rdf_parse.sv */
module tlv_rdf_parse
  import tlv_rdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  in_word_t    word,
  input  logic [15:0] max_record_len,
  input  logic [15:0] max_message_len,
  output push_t       push
);

  logic [1:0]  phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [15:0] tag_reg, tag_reg_next;
  logic [31:0] length_reg, length_reg_next;
  logic [15:0] value_count, value_count_next;
  logic [15:0] message_count, message_count_next;
  logic        error_hold, error_hold_next;

  logic [15:0] msg_count_inc;
  logic [2:0]  hc_plus;
  logic [1:0]  lane;
  logic [31:0] length_or;
  logic [16:0] vc_plus;
  logic [16:0] rec_total;
  logic        rec_long;
  logic        value_end;
  logic        err;
  logic [2:0]  err_code;
  logic        clear_msg;
  res_word_t   value_res;
  res_word_t   end_res;

  // Header arithmetic
  assign msg_count_inc = (message_count != 16'hFFFF) ? message_count + 16'd1 : message_count;
  assign hc_plus       = header_count + 3'd1;
  assign lane          = header_count[1:0] - 2'd2;
  assign length_or     = length_reg | ({24'd0, word.data_byte} << {lane, 3'b000});
  assign rec_total     = {1'b0, length_or[15:0]} + 17'd6;
  assign rec_long      = (length_or[31:16] != 16'd0) || (rec_total >= {1'b0, max_record_len});
  assign vc_plus       = {1'b0, value_count} + 17'd1;
  assign value_end     = {15'd0, vc_plus} >= length_reg;

  // Next state and results for one word
  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    tag_reg_next       = tag_reg;
    length_reg_next    = length_reg;
    value_count_next   = value_count;
    message_count_next = message_count;
    error_hold_next    = error_hold;
    push               = '0;
    err                = 1'b0;
    err_code           = ST_MSG_LONG;
    clear_msg          = 1'b0;
    value_res          = '0;
    end_res            = '0;

    if (fire) begin
      if (error_hold) begin
        clear_msg = word.last;
      end else begin
        message_count_next = msg_count_inc;
        if (msg_count_inc > max_message_len) begin
          err      = 1'b1;
          err_code = ST_MSG_LONG;
        end else begin
          case (phase)
            PH_TAG: begin
              tag_reg_next      = {tag_reg[7:0], word.data_byte};
              header_count_next = hc_plus;
              if (hc_plus >= TAG_BYTES) begin
                phase_next      = PH_LEN;
                length_reg_next = '0;
              end
            end
            PH_LEN: begin
              length_reg_next   = length_or;
              header_count_next = hc_plus;
              if (hc_plus >= HEADER_BYTES) begin
                header_count_next = '0;
                value_count_next  = '0;
                if (rec_long) begin
                  err      = 1'b1;
                  err_code = ST_REC_LONG;
                end else if (length_or == 32'd0) begin
                  value_res.status      = ST_VALUE;
                  value_res.tag         = tag_reg;
                  value_res.item_length = 16'd1;
                  value_res.value_index = 16'd0;
                  value_res.value_byte  = EMPTY_BYTE;
                  value_res.item_end    = 1'b1;
                  push.r0               = value_res;
                  push.count            = 2'd1;
                  phase_next            = PH_TAG;
                end else begin
                  phase_next = PH_VAL;
                end
              end
            end
            default: begin
              value_res.status      = ST_VALUE;
              value_res.tag         = tag_reg;
              value_res.item_length = length_reg[15:0];
              value_res.value_index = value_count;
              value_res.value_byte  = word.data_byte;
              value_res.item_end    = value_end;
              push.r0               = value_res;
              push.count            = 2'd1;
              value_count_next      = vc_plus[15:0];
              if (value_end) begin
                phase_next        = PH_TAG;
                header_count_next = '0;
                value_count_next  = '0;
              end
            end
          endcase
        end

        if (err) begin
          end_res.status = err_code;
          push.r0        = end_res;
          push.count     = 2'd1;
          if (word.last) begin
            clear_msg = 1'b1;
          end else begin
            error_hold_next = 1'b1;
            phase_next      = PH_DROP;
          end
        end else if (word.last) begin
          // done only on a clean record boundary
          end_res.status = ((phase_next == PH_TAG) && (header_count_next == 3'd0)) ?
                           ST_DONE : ST_TRUNC;
          if (push.count == 2'd1) begin
            push.r1    = end_res;
            push.count = 2'd2;
          end else begin
            push.r0    = end_res;
            push.count = 2'd1;
          end
          clear_msg = 1'b1;
        end
      end
    end

    if (clear_msg) begin
      phase_next         = PH_TAG;
      header_count_next  = '0;
      tag_reg_next       = '0;
      length_reg_next    = '0;
      value_count_next   = '0;
      message_count_next = '0;
      error_hold_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      header_count  <= '0;
      tag_reg       <= '0;
      length_reg    <= '0;
      value_count   <= '0;
      message_count <= '0;
      error_hold    <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      tag_reg       <= tag_reg_next;
      length_reg    <= length_reg_next;
      value_count   <= value_count_next;
      message_count <= message_count_next;
      error_hold    <= error_hold_next;
    end
  end

endmodule

/* src/tlv_rdf_outq.sv */
module tlv_rdf_outq
  import tlv_rdf_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  input  logic      result_ready,
  output logic      result_valid,
  output res_word_t result,
  output logic      room
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  res_word_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr_1;
  logic [CNT_W-1:0]   count;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_1     = ptr_inc(wr_ptr);
  assign pop          = result_valid && result_ready;
  assign result_valid = count != '0;
  assign result       = mem[rd_ptr];
  // room for the two results one word may produce
  assign room         = count <= CNT_W'(DEPTH - 2);

  always_comb begin
    case (push.count)
      2'd1:    wr_ptr_next = wr_ptr_1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
      default: wr_ptr_next = wr_ptr;
    endcase
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

/* src/tlv_record_deframer_core.sv */
// A word accepted into the input register is parsed once the queue has room, and its
// results (up to two: value byte plus end of message) go to the output queue.
// Throughput: one word per cycle while the queue has room for two results; one result
// per cycle leaves the queue when taken. Queue depth is OUT_DEPTH.
// Reset: synchronous, clears the parser, queue and input stage; limits return
// to 4096 (record) and 8192 (message).
module tlv_record_deframer_core
  import tlv_rdf_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  in_word_t             item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output res_word_t            result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] max_record_len;
  logic [15:0] max_message_len;
  in_word_t    item_r;
  logic        item_r_valid;
  logic        room;
  logic        fire;
  push_t       push;

  assign cfg_ready  = 1'b1;
  assign fire       = item_r_valid && room;
  assign item_ready = !item_r_valid || fire;

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_len  <= MAX_RECORD_RST;
      max_message_len <= MAX_MESSAGE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_RECORD:  max_record_len  <= cfg_data;
        REG_MAX_MESSAGE: max_message_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_r_valid <= 1'b0;
    end else if (item_ready) begin
      item_r_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_r <= item;
    end
  end

  tlv_rdf_parse u_parse (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .word            (item_r),
    .max_record_len  (max_record_len),
    .max_message_len (max_message_len),
    .push            (push)
  );

  tlv_rdf_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .room         (room)
  );

endmodule

/* src/tlv_rdf_checker.sv */
`include "tlv_record_deframer_core_defines.svh"

module tlv_rdf_checker
  import tlv_rdf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_ready,
  input logic      result_valid,
  input logic      result_ready,
  input res_word_t result
);

  // nothing pending right after reset
  `TLV_RDF_ASSERT_NEXT_ALWAYS(a_rst_no_result, clk, rst, !result_valid, "result after reset")
  `TLV_RDF_ASSERT_NEXT_ALWAYS(a_rst_ready, clk, rst, item_ready, "not ready after reset")
  // a stalled result word holds
  `TLV_RDF_ASSERT_NEXT(a_res_hold, clk, rst, result_valid && !result_ready,
    result_valid && $stable(result), "stalled result word changed")

endmodule

bind tlv_record_deframer_core tlv_rdf_checker u_checker (.*);

/* tb/sv/tlv_record_deframer_core_tb.sv */
`timescale 1ns / 100ps

module tlv_record_deframer_core_tb
  import tlv_rdf_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 600000;

  // Tracks the parser and holds the result words still due from the block
  class deframer_scoreboard;
    logic [15:0] rec_limit;
    logic [15:0] msg_limit;
    logic [1:0]  parse_phase;
    int unsigned hdr_cnt;
    logic [15:0] tag_acc;
    logic [31:0] len_acc;
    logic [15:0] val_cnt;
    logic [15:0] msg_cnt;
    bit          dropping;
    res_word_t   results_due[$];
    int unsigned mismatches;

    function new();
      rec_limit = MAX_RECORD_RST;
      msg_limit = MAX_MESSAGE_RST;
      mismatches = 0;
      restart_message();
    endfunction

    function void restart_message();
      parse_phase = PH_TAG;
      hdr_cnt = 0;
      tag_acc = '0;
      len_acc = '0;
      val_cnt = '0;
      msg_cnt = '0;
      dropping = 1'b0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == REG_MAX_RECORD) begin
        rec_limit = val;
      end else if (idx == REG_MAX_MESSAGE) begin
        msg_limit = val;
      end
    endfunction

    function void queue_result(logic [2:0] st, logic [15:0] tg, logic [15:0] len,
                               logic [15:0] idx, logic [7:0] vb, logic fin);
      res_word_t r;
      r.status = st;
      r.tag = tg;
      r.item_length = len;
      r.value_index = idx;
      r.value_byte = vb;
      r.item_end = fin;
      results_due.insert(results_due.size(), r);
    endfunction

    // Returns 1 when the word is parsed, 0 when it is dropped after an error
    function bit note_word(in_word_t w);
      bit          has_err;
      logic [2:0]  err;
      logic [32:0] total;
      bit          fin;
      has_err = 1'b0;
      err = ST_VALUE;
      if (dropping) begin
        if (w.last) restart_message();
        return 1'b0;
      end
      if (msg_cnt != 16'hFFFF) msg_cnt++;
      // message length check wins over anything the byte would do
      if (msg_cnt > msg_limit) begin
        has_err = 1'b1;
        err = ST_MSG_LONG;
      end else if (parse_phase == PH_TAG) begin
        tag_acc = {tag_acc[7:0], w.data_byte};
        hdr_cnt++;
        if (hdr_cnt >= TAG_BYTES) begin
          parse_phase = PH_LEN;
          len_acc = '0;
        end
      end else if (parse_phase == PH_LEN) begin
        // length is little endian
        len_acc[8*(hdr_cnt-TAG_BYTES) +: 8] = w.data_byte;
        hdr_cnt++;
        if (hdr_cnt >= HEADER_BYTES) begin
          total = {1'b0, len_acc} + 33'(HEADER_BYTES);
          hdr_cnt = 0;
          val_cnt = '0;
          if (total >= {17'b0, rec_limit}) begin
            has_err = 1'b1;
            err = ST_REC_LONG;
          end else if (len_acc == '0) begin
            // empty record stands in as one ASCII zero
            queue_result(ST_VALUE, tag_acc, 16'd1, 16'd0, EMPTY_BYTE, 1'b1);
            parse_phase = PH_TAG;
          end else begin
            parse_phase = PH_VAL;
          end
        end
      end else begin
        fin = ({16'b0, val_cnt} + 32'd1) >= len_acc;
        queue_result(ST_VALUE, tag_acc, len_acc[15:0], val_cnt, w.data_byte, fin);
        val_cnt++;
        if (fin) begin
          parse_phase = PH_TAG;
          hdr_cnt = 0;
          val_cnt = '0;
        end
      end

      if (has_err) begin
        queue_result(err, '0, '0, '0, '0, 1'b0);
        if (w.last) begin
          restart_message();
        end else begin
          dropping = 1'b1;
          parse_phase = PH_DROP;
        end
        return 1'b1;
      end

      // end of message: clean on a record boundary, otherwise cut off
      if (w.last) begin
        if (parse_phase == PH_TAG && hdr_cnt == 0) begin
          queue_result(ST_DONE, '0, '0, '0, '0, 1'b0);
        end else begin
          queue_result(ST_TRUNC, '0, '0, '0, '0, 1'b0);
        end
        restart_message();
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_word_t got);
      res_word_t want;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got %0h", $time, got);
        return;
      end
      want = results_due[0];
      results_due.delete(0);
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("tag", 32'(want.tag), 32'(got.tag));
      compare_field("item_length", 32'(want.item_length), 32'(got.item_length));
      compare_field("value_index", 32'(want.value_index), 32'(got.value_index));
      compare_field("value_byte", 32'(want.value_byte), 32'(got.value_byte));
      compare_field("item_end", 32'(want.item_end), 32'(got.item_end));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  in_word_t             item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  res_word_t            result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_RECORD;
  logic [15:0]          cfg_data = '0;

  deframer_scoreboard sb = new();

  int unsigned rec_lim = MAX_RECORD_RST;
  int unsigned msg_lim = MAX_MESSAGE_RST;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent_words = 0;
  int unsigned cycles = 0;
  logic [7:0]  frame[$];

  tlv_record_deframer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL tlv_record_deframer_core");
      $finish;
    end
  end

  // Result side: random stall, check on every accepted word
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    void'(sb.note_word(w));
    sent_words++;
    @(negedge clk);
  endtask

  // Sends the frame buffer as one message, last on its final byte
  task automatic send_frame();
    in_word_t w;
    for (int i = 0; i < frame.size(); i++) begin
      w.data_byte = frame[i];
      w.last = (i == frame.size() - 1);
      send_word(w);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(idx, val);
    @(negedge clk);
  endtask

  // Wait for the block to go quiet: nothing due, pipeline flushed
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic void push_header(logic [15:0] tg, logic [31:0] len);
    frame.insert(frame.size(), tg[15:8]);
    frame.insert(frame.size(), tg[7:0]);
    for (int k = 0; k < 4; k++) frame.insert(frame.size(), len[8*k +: 8]);
  endfunction

  // Value length of a record that passes the record limit (when the limit is at least 7), boundary favored
  function automatic int unsigned pick_len();
    int unsigned r;
    int unsigned len;
    int unsigned cap;
    r = $urandom_range(99);
    if (r < 2) len = $urandom_range(300, 256);
    else if (r < 12) len = $urandom_range(40, 7);
    else len = $urandom_range(6, 0);
    cap = (rec_lim >= 7) ? rec_lim - 7 : 0;
    if (len > cap) len = cap;
    return len;
  endfunction

  function automatic void build_message();
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [31:0] big;
    frame.delete();
    pick = $urandom_range(99);
    if (pick < 10) begin
      // raw noise
      repeat ($urandom_range(20, 1)) frame.insert(frame.size(), 8'($urandom()));
    end else if (pick < 22) begin
      // record over the limit, then bytes that get dropped
      if ($urandom_range(1) == 1) big = $urandom() | 32'h0001_0000;
      else big = ((rec_lim > 6) ? rec_lim - 6 : 0) + $urandom_range(3);
      push_header(16'($urandom()), big);
      repeat ($urandom_range(4)) frame.insert(frame.size(), 8'($urandom()));
    end else begin
      // well-formed records; some messages cut short
      repeat ($urandom_range(4, 1)) begin
        len = pick_len();
        push_header(16'($urandom()), len);
        repeat (len) frame.insert(frame.size(), 8'($urandom()));
      end
      if (pick < 34) begin
        cut = $urandom_range(frame.size() - 1, 1);
        repeat (cut) void'(frame.pop_back());
      end
    end
  endfunction

  task automatic run_phase(input logic [15:0] rl, input logic [15:0] ml,
                           input int unsigned idle_s, input int unsigned stall_r,
                           input int unsigned budget);
    settle();
    write_reg(REG_MAX_RECORD, rl);
    write_reg(REG_MAX_MESSAGE, ml);
    cfg_valid <= 1'b0;
    rec_lim = rl;
    msg_lim = ml;
    sender_idle_pct = idle_s;
    recv_stall_pct = stall_r;
    sent_words = 0;
    while (sent_words < budget) begin
      build_message();
      send_frame();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty record ending the message
    frame.delete();
    push_header(16'hFF00, 32'd0);
    send_frame();
    // two value bytes at the byte extremes, done on the last one
    frame.delete();
    push_header(16'h00FF, 32'd2);
    frame.insert(frame.size(), 8'hFF);
    frame.insert(frame.size(), 8'h00);
    send_frame();
    // record too long, detected on the final byte
    frame.delete();
    push_header(16'hA55A, 32'hFFFF_FFFF);
    send_frame();
    // message cut off inside the tag
    frame.delete();
    frame.insert(frame.size(), 8'h80);
    send_frame();

    // Random phases over several limit settings and flow patterns
    run_phase(16'd4096, 16'd8192, 0, 0, 200);
    run_phase(16'd7, 16'd65535, 86, 0, 150);
    run_phase(16'd65535, 16'd65535, 0, 86, 250);
    run_phase(16'd20, 16'd40, 9, 9, 200);
    run_phase(16'd65535, 16'd1, 0, 0, 60);
    run_phase(16'd6, 16'd0, 86, 0, 40);
    run_phase(16'd300, 16'd12, 0, 86, 150);
    run_phase(16'd4096, 16'd8192, 9, 9, 300);

    settle();
    if (sb.mismatches == 0) begin
      $display("PASS tlv_record_deframer_core");
    end else begin
      $display("FAIL tlv_record_deframer_core");
    end
    $finish;
  end

endmodule
